// ===== hdl/matrix4_inverse_determinant_assert.svh =====
// ----------------------------------------------------------------------------
// matrix4_inverse_determinant assertion macros
// shared property forms for the matrix inverse block
// ----------------------------------------------------------------------------
`ifndef MATRIX4_INVERSE_DETERMINANT_ASSERT_SVH
`define MATRIX4_INVERSE_DETERMINANT_ASSERT_SVH

// same-cycle implication
`define M4INV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define M4INV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/m4inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m4inv_pkg
// types, command and status structs and index tables of the matrix inverse
// ----------------------------------------------------------------------------
`default_nettype none

package m4inv_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_OPA,
		ST_OPB,
		ST_MWAIT,
		ST_DIV,
		ST_DWAIT,
		ST_OUT,
		ST_ZOUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MINOR,
		PH_DET,
		PH_ADJ
	} phase_t;

	typedef struct packed {
		logic       elem_wr;
		logic [3:0] elem_idx;
		logic       opnd_minor;
		logic [3:0] opnd_idx;
		logic       ld_a;
		logic       ld_b;
		logic       acc_upd;
		logic       acc_clr;
		logic       acc_sub;
		logic       minor_wr;
		logic [3:0] minor_idx;
		logic       det_wr;
		logic       div_start;
		logic       div_det;
		logic       out_load;
		logic       out_zero;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic det_zero;
		logic out_free;
	} status_t;

	// first column of 2x2 minor p
	function automatic logic [1:0] pair_ca(input logic [2:0] p);
		case (p)
			3'd3, 3'd4: pair_ca = 2'd1;
			3'd5:       pair_ca = 2'd2;
			default:    pair_ca = 2'd0;
		endcase
	endfunction

	// second column of 2x2 minor p
	function automatic logic [1:0] pair_cb(input logic [2:0] p);
		case (p)
			3'd0:       pair_cb = 2'd1;
			3'd1, 3'd3: pair_cb = 2'd2;
			default:    pair_cb = 2'd3;
		endcase
	endfunction

	function automatic logic [1:0] src_row(input logic [1:0] j);
		case (j)
			2'd0:    src_row = 2'd1;
			2'd1:    src_row = 2'd0;
			2'd2:    src_row = 2'd3;
			default: src_row = 2'd2;
		endcase
	endfunction

	// columns other than i, ascending
	function automatic logic [1:0] adj_col(input logic [1:0] i, input logic [1:0] t);
		adj_col = (t >= i) ? 2'(t + 2'd1) : t;
	endfunction

	function automatic logic [2:0] adj_min(input logic [1:0] i, input logic [1:0] t);
		case ({i, t})
			4'b00_00: adj_min = 3'd5;
			4'b00_01: adj_min = 3'd4;
			4'b00_10: adj_min = 3'd3;
			4'b01_00: adj_min = 3'd5;
			4'b01_01: adj_min = 3'd2;
			4'b01_10: adj_min = 3'd1;
			4'b10_00: adj_min = 3'd4;
			4'b10_01: adj_min = 3'd2;
			4'b10_10: adj_min = 3'd0;
			4'b11_00: adj_min = 3'd3;
			4'b11_01: adj_min = 3'd1;
			default:  adj_min = 3'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hdl/m4inv_ctrl.sv =====
// ----------------------------------------------------------------------------
// m4inv_ctrl
// sequencer: load, minors, determinant, adjugate terms, divisions, results
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_func,
	output logic              s_tready,
	input  m4inv_pkg::status_t status,
	output m4inv_pkg::cmd_t    cmd
);
	import m4inv_pkg::*;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [3:0] load_cnt_q, load_cnt_d;
	logic       func_q, func_d;
	logic [3:0] grp_q, grp_d;
	logic [2:0] term_q, term_d;

	logic       half;
	logic [2:0] pidx;
	logic [1:0] r0, r1, ca, cb, ai, aj, arow, acol;
	logic [1:0] t2;
	logic       a_minor, b_minor, t_sub, t_last;
	logic [3:0] a_idx, b_idx;

	// operand selection for the current product term
	always_comb begin
		half = (grp_q >= 4'd6);
		pidx = half ? 3'(grp_q - 4'd6) : grp_q[2:0];
		r0 = {half, 1'b0};
		r1 = {half, 1'b1};
		ca = pair_ca(pidx);
		cb = pair_cb(pidx);
		ai = grp_q[3:2];
		aj = grp_q[1:0];
		t2 = term_q[1:0];
		arow = src_row(aj);
		acol = adj_col(ai, t2);
		a_minor = 1'b0;
		b_minor = 1'b0;
		a_idx = '0;
		b_idx = '0;
		t_sub = 1'b0;
		t_last = 1'b0;
		case (phase_q)
			PH_MINOR: begin
				a_idx = term_q[0] ? {r1, ca} : {r0, ca};
				b_idx = term_q[0] ? {r0, cb} : {r1, cb};
				t_sub = term_q[0];
				t_last = (term_q == 3'd1);
			end
			PH_DET: begin
				a_minor = 1'b1;
				b_minor = 1'b1;
				a_idx = 4'(term_q);
				b_idx = 4'(4'd11 - 4'(term_q));
				t_sub = (term_q == 3'd1) || (term_q == 3'd4);
				t_last = (term_q == 3'd5);
			end
			PH_ADJ: begin
				b_minor = 1'b1;
				a_idx = {arow, acol};
				b_idx = ((aj < 2'd2) ? 4'd6 : 4'd0) + 4'(adj_min(ai, t2));
				t_sub = term_q[0] ^ ai[0] ^ aj[0];
				t_last = (term_q == 3'd2);
			end
			default: begin
				t_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_MINOR;
			load_cnt_q <= '0;
			func_q <= 1'b0;
			grp_q <= '0;
			term_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			load_cnt_q <= load_cnt_d;
			func_q <= func_d;
			grp_q <= grp_d;
			term_q <= term_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		load_cnt_d = load_cnt_q;
		func_d = func_q;
		grp_d = grp_q;
		term_d = term_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.elem_wr = 1'b1;
					cmd.elem_idx = load_cnt_q;
					load_cnt_d = load_cnt_q + 4'd1;
					if (load_cnt_q == 4'd15) begin
						func_d = s_func;
						phase_d = PH_MINOR;
						grp_d = '0;
						term_d = '0;
						state_d = ST_OPA;
					end
				end
			end
			ST_OPA: begin
				cmd.ld_a = 1'b1;
				cmd.opnd_minor = a_minor;
				cmd.opnd_idx = a_idx;
				state_d = ST_OPB;
			end
			ST_OPB: begin
				cmd.ld_b = 1'b1;
				cmd.opnd_minor = b_minor;
				cmd.opnd_idx = b_idx;
				state_d = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (!status.mul_busy) begin
					cmd.acc_upd = 1'b1;
					cmd.acc_clr = (term_q == 3'd0);
					cmd.acc_sub = t_sub;
					if (!t_last) begin
						term_d = term_q + 3'd1;
						state_d = ST_OPA;
					end else begin
						term_d = '0;
						case (phase_q)
							PH_MINOR: begin
								cmd.minor_wr = 1'b1;
								cmd.minor_idx = grp_q;
								state_d = ST_OPA;
								if (grp_q == 4'd11) begin
									phase_d = PH_DET;
									grp_d = '0;
								end else begin
									grp_d = grp_q + 4'd1;
								end
							end
							PH_DET: begin
								cmd.det_wr = 1'b1;
								state_d = ST_DIV;
							end
							default: begin
								state_d = ST_DIV;
							end
						endcase
					end
				end
			end
			ST_DIV: begin
				if (phase_q == PH_ADJ) begin
					cmd.div_start = 1'b1;
					state_d = ST_DWAIT;
				end else if (func_q) begin
					cmd.div_start = 1'b1;
					cmd.div_det = 1'b1;
					state_d = ST_DWAIT;
				end else if (status.det_zero) begin
					grp_d = '0;
					state_d = ST_ZOUT;
				end else begin
					phase_d = PH_ADJ;
					grp_d = '0;
					term_d = '0;
					state_d = ST_OPA;
				end
			end
			ST_DWAIT: begin
				if (!status.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = func_q || (grp_q == 4'd15);
					if (func_q || (grp_q == 4'd15)) begin
						state_d = ST_LOAD;
					end else begin
						grp_d = grp_q + 4'd1;
						state_d = ST_OPA;
					end
				end
			end
			ST_ZOUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_zero = 1'b1;
					cmd.out_last = (grp_q == 4'd15);
					if (grp_q == 4'd15) begin
						state_d = ST_LOAD;
					end else begin
						grp_d = grp_q + 4'd1;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/m4inv_dp.sv =====
// ----------------------------------------------------------------------------
// m4inv_dp
// datapath: element and minor store, serial multiplier, accumulator,
// restoring divider, saturation and result register
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_dp #(
	parameter int ELEM_WIDTH = m4inv_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [ELEM_WIDTH-1:0] element,
	input  m4inv_pkg::cmd_t              cmd,
	output m4inv_pkg::status_t           status,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic signed [ELEM_WIDTH-1:0] value,
	output logic                         last,
	output logic                         singular,
	output logic                         overflow
);
	import m4inv_pkg::*;

	localparam int W    = ELEM_WIDTH;
	localparam int MW   = 2 * W + 1;
	localparam int PW   = 2 * MW;
	localparam int ACW  = 4 * W + 5;
	localparam int NUMW = 3 * W + 3 + 2 * FRAC_BITS;
	localparam int DVW  = (ACW > NUMW) ? ACW : NUMW;
	localparam int MCW  = $clog2(MW + 1);
	localparam int DCW  = $clog2(DVW + 1);

	logic signed [W-1:0]   elem_q [16];
	logic signed [MW-1:0]  minor_q [12];
	logic signed [ACW-1:0] acc_q, det_q, acc_d;
	logic signed [MW-1:0]  opnd, opa_q;

	logic signed [PW-1:0]  mc_q, prod_q;
	logic [MW-1:0]         mb_q;
	logic [MCW-1:0]        mcnt_q;
	logic                  mbusy_q;

	logic signed [DVW-1:0] num_s, den_s;
	logic [DVW-1:0]        num_abs, den_abs;
	logic [DVW-1:0]        dn_q, dd_q, rem_q, quo_q;
	logic [DVW:0]          r_sh;
	logic                  ge;
	logic                  dneg_q;
	logic [DCW-1:0]        dcnt_q;
	logic                  dbusy_q;
	logic signed [DVW:0]   qs;
	logic                  sat;
	logic signed [W-1:0]   qv;

	logic                  valid_q;

	assign opnd = cmd.opnd_minor ? minor_q[cmd.opnd_idx] : MW'(elem_q[cmd.opnd_idx]);

	always_comb begin
		acc_d = (cmd.acc_clr ? '0 : acc_q);
		if (cmd.acc_sub) begin
			acc_d = acc_d - ACW'(prod_q);
		end else begin
			acc_d = acc_d + ACW'(prod_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.elem_wr) begin
			elem_q[cmd.elem_idx] <= element;
		end
		if (cmd.ld_a) begin
			opa_q <= opnd;
		end
		if (cmd.acc_upd) begin
			acc_q <= acc_d;
		end
		if (cmd.minor_wr) begin
			minor_q[cmd.minor_idx] <= acc_d[MW-1:0];
		end
		if (cmd.det_wr) begin
			det_q <= acc_d;
		end
	end

	// shift-add multiplier, top multiplier bit carries negative weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q <= '0;
		end else if (cmd.ld_b) begin
			mbusy_q <= 1'b1;
			mcnt_q <= MCW'(MW);
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q - 1'b1;
			if (mcnt_q == MCW'(1)) begin
				mbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_b) begin
			mc_q <= PW'(opa_q);
			mb_q <= opnd;
			prod_q <= '0;
		end else if (mbusy_q) begin
			if (mb_q[0]) begin
				prod_q <= (mcnt_q == MCW'(1)) ? prod_q - mc_q : prod_q + mc_q;
			end
			mc_q <= mc_q <<< 1;
			mb_q <= mb_q >> 1;
		end
	end

	// divider operands, determinant scaling is a shift of the magnitude
	always_comb begin
		if (cmd.div_det) begin
			num_s = DVW'(det_q);
		end else begin
			num_s = DVW'(acc_q) <<< (2 * FRAC_BITS);
		end
		den_s = DVW'(det_q);
		num_abs = num_s[DVW-1] ? DVW'(-num_s) : DVW'(num_s);
		den_abs = den_s[DVW-1] ? DVW'(-den_s) : DVW'(den_s);
		r_sh = {rem_q, dn_q[DVW-1]};
		ge = (r_sh >= {1'b0, dd_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cmd.div_start && !cmd.div_det) begin
			dbusy_q <= 1'b1;
			dcnt_q <= DCW'(DVW);
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (dcnt_q == DCW'(1)) begin
				dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dn_q <= num_abs;
			dd_q <= den_abs;
			rem_q <= '0;
			if (cmd.div_det) begin
				quo_q <= num_abs >> (3 * FRAC_BITS);
				dneg_q <= num_s[DVW-1];
			end else begin
				quo_q <= '0;
				dneg_q <= num_s[DVW-1] ^ den_s[DVW-1];
			end
		end else if (dbusy_q) begin
			dn_q <= dn_q << 1;
			rem_q <= ge ? DVW'(r_sh - {1'b0, dd_q}) : r_sh[DVW-1:0];
			quo_q <= {quo_q[DVW-2:0], ge};
		end
	end

	// sign and saturation of the quotient
	always_comb begin
		qs = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		sat = !((qs[DVW:W-1] == '0) || (qs[DVW:W-1] == '1));
		if (!sat) begin
			qv = qs[W-1:0];
		end else if (qs[DVW]) begin
			qv = {1'b1, {(W-1){1'b0}}};
		end else begin
			qv = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value <= cmd.out_zero ? '0 : qv;
			overflow <= cmd.out_zero ? 1'b0 : sat;
			singular <= (det_q == '0);
			last <= cmd.out_last;
		end
	end

	assign out_valid = valid_q;
	assign status.mul_busy = mbusy_q;
	assign status.div_busy = dbusy_q;
	assign status.det_zero = (det_q == '0);
	assign status.out_free = !valid_q || out_ready;

endmodule

`default_nettype wire

// ===== hdl/matrix4_inverse_determinant.sv =====
// ----------------------------------------------------------------------------
// matrix4_inverse_determinant
// 4x4 signed fixed-point determinant and inverse by the adjugate method
// ----------------------------------------------------------------------------
// Sixteen elements enter in row-major order, one per cycle while s_tready is
// high; the func bit of the sixteenth selects inverse (0) or determinant (1).
// The work then runs on one serial multiplier and one restoring divider, both
// one bit per cycle: 78 products (24 minor, 6 determinant, 48 adjugate terms),
// plus per inverse entry a division. A determinant run uses 30 products and a
// shift by 3*FRAC_BITS; a singular inverse skips the adjugate and gives 16 zero
// results at one per cycle while m_tready is high. The last result can wait in
// the output register while the next matrix loads.
`default_nettype none

module matrix4_inverse_determinant #(
	parameter int ELEM_WIDTH = m4inv_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((ELEM_WIDTH+7)/8)*8-1:0]     s_tdata,  // element
	input  logic                                s_tuser,  // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((ELEM_WIDTH+7)/8)*8-1:0]     m_tdata,  // value
	output logic                                m_tlast,
	output logic [1:0]                          m_tuser   // {overflow, singular}
);
	import m4inv_pkg::*;

`include "matrix4_inverse_determinant_assert.svh"

	localparam int TDW = ((ELEM_WIDTH + 7) / 8) * 8;

	cmd_t                         cmd;
	status_t                      status;
	logic signed [ELEM_WIDTH-1:0] value;
	logic                         singular, overflow;

	m4inv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	m4inv_dp #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.element   ($signed(s_tdata[ELEM_WIDTH-1:0])),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.value     (value),
		.last      (m_tlast),
		.singular  (singular),
		.overflow  (overflow)
	);

	assign m_tdata = TDW'($unsigned(value));
	assign m_tuser = {overflow, singular};

	`M4INV_ASSERT_NOW(a_no_overwrite, cmd.out_load, status.out_free, "pending result overwritten")
	`M4INV_ASSERT_NEXT(a_out_valid, cmd.out_load, m_tvalid, "loaded result not presented")
	`M4INV_ASSERT_NOW(a_mul_idle, cmd.ld_b, !status.mul_busy, "multiply started while busy")
	`M4INV_ASSERT_NOW(a_load_idle, s_tready, !status.mul_busy && !status.div_busy,
		"input taken while arithmetic busy")

endmodule

`default_nettype wire

// ===== sim/tb_matrix4_inverse_determinant.sv =====
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_determinant
// self-checking testbench of the 4x4 fixed-point determinant and inverse
// ----------------------------------------------------------------------------
// Matrices stream in as sixteen element transactions. A predictor working in
// wide exact integers computes the determinant or the sixteen inverse entries
// with truncation and saturation, and a monitor compares every result
// transaction with the oldest prediction. Both sides idle at random; the
// receiver is once held off for a long stretch and the sender twice waits for
// all results to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_matrix4_inverse_determinant;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic              func;
		logic signed [31:0] element;
		logic              drain;
	} elem_item_t;

	typedef struct {
		logic [31:0] value;
		logic        last;
		logic        singular;
		logic        overflow;
	} result_t;

	localparam int SRC_ROW [4]    = '{1, 0, 3, 2};
	localparam int PAIR_A [6]     = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_B [6]     = '{1, 2, 3, 2, 3, 3};
	localparam int ADJ_MIN [4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // element
	logic        s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // value
	logic        m_tlast;
	logic [1:0]  m_tuser;   // {overflow, singular}

	elem_item_t         pending_elems[$];
	result_t            expected_results[$];
	logic signed [31:0] matrix_copy[16];
	int                 load_index;
	int                 errors;
	logic               tx_idle_en;
	logic               rx_idle_en;
	int                 rx_hold_cycles;

	matrix4_inverse_determinant dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("tb_matrix4_inverse_determinant: done, errors");
		$finish;
	end

	function automatic wide_t cell_at(int r, int c);
		wide_t w;
		w = matrix_copy[r * 4 + c];
		return w;
	endfunction

	function automatic result_t saturate(wide_t x, logic last, logic sing);
		result_t res;
		res.last     = last;
		res.singular = sing;
		res.overflow = 1'b0;
		if (x > wide_t'(32'sh7fffffff)) begin
			res.value    = 32'h7fffffff;
			res.overflow = 1'b1;
		end else if (x < -wide_t'(33'sh080000000)) begin
			res.value    = 32'h80000000;
			res.overflow = 1'b1;
		end else begin
			res.value = x[31:0];
		end
		return res;
	endfunction

	// exact determinant / adjugate over the stored matrix
	task automatic predict_matrix(logic func);
		wide_t   up[6];
		wide_t   lo[6];
		wide_t   det;
		wide_t   acc;
		wide_t   term;
		wide_t   one48;
		logic    sing;
		int      i;
		int      j;
		int      t;
		int      col;
		result_t res;
		for (int p = 0; p < 6; p++) begin
			up[p] = cell_at(0, PAIR_A[p]) * cell_at(1, PAIR_B[p])
			      - cell_at(1, PAIR_A[p]) * cell_at(0, PAIR_B[p]);
			lo[p] = cell_at(2, PAIR_A[p]) * cell_at(3, PAIR_B[p])
			      - cell_at(3, PAIR_A[p]) * cell_at(2, PAIR_B[p]);
		end
		det = up[0] * lo[5] - up[1] * lo[4] + up[2] * lo[3]
		    + up[3] * lo[2] - up[4] * lo[1] + up[5] * lo[0];
		sing  = (det == 0);
		one48 = 1;
		one48 = one48 <<< 48;
		if (func) begin
			expected_results.push_back(saturate(det / one48, 1'b1, sing));
		end else begin
			for (int k = 0; k < 16; k++) begin
				i = k / 4;
				j = k % 4;
				acc = 0;
				if (!sing) begin
					for (t = 0; t < 3; t++) begin
						col  = (t >= i) ? t + 1 : t;
						term = cell_at(SRC_ROW[j], col)
						     * ((j < 2) ? lo[ADJ_MIN[i][t]] : up[ADJ_MIN[i][t]]);
						if (((t & 1) ^ ((i + j) & 1)) != 0)
							acc = acc - term;
						else
							acc = acc + term;
					end
					acc = (acc <<< 32) / det;
				end
				res = saturate(acc, k == 15, sing);
				expected_results.push_back(res);
			end
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			load_index = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				matrix_copy[load_index] = s_tdata;
				load_index = load_index + 1;
				if (load_index == 16) begin
					load_index = 0;
					predict_matrix(s_tuser);
				end
				void'(pending_elems.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (pending_elems.size() > 0 && pending_elems[0].drain
				    && expected_results.size() == 0)
					void'(pending_elems.pop_front());
				if (pending_elems.size() > 0 && !pending_elems[0].drain
				    && !(tx_idle_en && $urandom_range(99) < 26)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_elems[0].element;
					s_tuser  <= pending_elems[0].func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold_cycles > 0) begin
			rx_hold_cycles = rx_hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(rx_idle_en && $urandom_range(99) < 26);
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected result transaction value %h", $realtime, m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.value || m_tlast !== want.last
				    || m_tuser[0] !== want.singular || m_tuser[1] !== want.overflow) begin
					errors = errors + 1;
					$display("%0t: mismatch expected value %h last %b sing %b ovf %b, actual %h %b %b %b",
						$realtime, want.value, want.last, want.singular, want.overflow,
						m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
				end
			end
		end
	end

	task automatic queue_matrix(logic func, logic signed [31:0] m[16]);
		elem_item_t it;
		for (int k = 0; k < 16; k++) begin
			it.func    = (k == 15) ? func : 1'($urandom_range(1));
			it.element = m[k];
			it.drain   = 1'b0;
			pending_elems.push_back(it);
		end
	endtask

	task automatic queue_drain();
		elem_item_t it;
		it.func    = 1'b0;
		it.element = '0;
		it.drain   = 1'b1;
		pending_elems.push_back(it);
	endtask

	task automatic queue_random_matrix();
		logic signed [31:0] m[16];
		int kind;
		int src;
		int dst;
		kind = $urandom_range(9);
		for (int k = 0; k < 16; k++) begin
			case (kind)
				0, 1:    m[k] = $urandom;
				7:       m[k] = $signed($urandom_range(8 * 65536)) - 4 * 65536;
				8:       m[k] = $signed($urandom_range(64)) - 32;
				9:       m[k] = ($signed($urandom_range(8)) - 4) * 65536;
				default: m[k] = (k % 5 == 0)
					? ($urandom_range(1) ? 1 : -1) * $signed($urandom_range(65536, 4 * 65536))
					: $signed($urandom_range(65535)) - 32768;
			endcase
		end
		if (kind == 7) begin
			src = $urandom_range(3);
			dst = (src + 1 + $urandom_range(2)) % 4;
			for (int c = 0; c < 4; c++)
				m[dst * 4 + c] = m[src * 4 + c];
		end
		queue_matrix($urandom_range(99) < 30, m);
	endtask

	initial begin
		logic signed [31:0] m[16];
		arst_n         = 1'b0;
		errors         = 0;
		tx_idle_en     = 1'b0;
		rx_idle_en     = 1'b0;
		rx_hold_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity, both operations
		for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sh10000 : 32'sh0;
		queue_matrix(1'b0, m);
		queue_matrix(1'b1, m);
		// tiny diagonal: inverse saturates
		for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sh1 : 32'sh0;
		queue_matrix(1'b0, m);
		// extreme diagonals: determinant saturates both ways
		for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sh7fffffff : 32'sh0;
		queue_matrix(1'b1, m);
		for (int k = 0; k < 16; k++)
			m[k] = (k == 0) ? 32'sh80000000 : (k % 5 == 0) ? 32'sh7fffffff : 32'sh0;
		queue_matrix(1'b1, m);
		// singular: all equal extremes, both operations
		for (int k = 0; k < 16; k++) m[k] = 32'sh80000000;
		queue_matrix(1'b0, m);
		for (int k = 0; k < 16; k++) m[k] = 32'sh7fffffff;
		queue_matrix(1'b1, m);
		queue_drain();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		for (int n = 0; n < 4; n++) queue_random_matrix();
		queue_drain();
		while (pending_elems.size() > 0) @(posedge clk);
		@(negedge clk);
		rx_hold_cycles = 20000;
		for (int n = 0; n < 4; n++) queue_random_matrix();
		for (int n = 0; n < 4; n++) queue_random_matrix();

		while (pending_elems.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_matrix4_inverse_determinant: done, clean");
		else
			$display("tb_matrix4_inverse_determinant: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
